// ----- rtl/core/drs_pkg.sv -----
// package with the parser state type and wire-format constants
`timescale 1ns / 1ps

package drs_pkg;

   // parse phase within one resource record
   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_LENGTH = 3'd1,
      PH_LABEL  = 3'd2,
      PH_PTR    = 3'd3,
      PH_FIXED  = 3'd4,
      PH_RDHI   = 3'd5,
      PH_RDLO   = 3'd6,
      PH_RDATA  = 3'd7
   } phase_type;

   // top two bits of a label length mark a pointer or a reserved label type
   localparam logic [7:0]  PTR_MASK = 8'hc0;
   // fixed part after the name: type and class, plus ttl for a full record
   localparam logic [15:0] Q_FIXED  = 16'd4;
   localparam logic [15:0] RR_FIXED = 16'd8;

endpackage

// ----- rtl/core/drs_if.sv -----
// valid/ready channel interfaces for packet bytes and per-byte results
`timescale 1ns / 1ps

interface drs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   logic       question_record;

   modport source (output valid, output data_byte, output last_byte,
                   output question_record, input ready);
   modport sink   (input valid, input data_byte, input last_byte,
                   input question_record, output ready);
endinterface

interface drs_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_done;
   logic        truncated;
   logic [15:0] rdata_length;

   modport source (output valid, output record_done, output truncated,
                   output rdata_length, input ready);
   modport sink   (input valid, input record_done, input truncated,
                   input rdata_length, output ready);
endinterface

// ----- rtl/core/dns_record_skipper_top.sv -----
// dns record boundary finder: walks names, fixed fields and rdata per byte
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-------------
//   req_if   | in  | data_byte[8], last_byte, question_record  | valid/ready
//   rsp_if   | out | record_done, truncated, rdata_length[16]  | valid/ready
//
// one byte per cycle while the output register is free or draining: the parse
// state updates at the accepting edge and the result lands in a single output register at that same edge
// req_if.ready is high while the output register is empty or being drained
// a stalled result holds its register and blocks only further input bytes
// synchronous active-high reset returns the parser to record start
`timescale 1ns / 1ps

module dns_record_skipper_top
   import drs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   drs_req_if.sink       req_if,
   drs_rsp_if.source     rsp_if
);

   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic        is_question_ff, is_question_in;
   logic [15:0] data_length_ff, data_length_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        record_done_ff, record_done_in;
   logic        truncated_ff, truncated_in;
   logic [15:0] rdata_length_ff, rdata_length_in;

   logic        req_accept;
   logic        done;
   logic        trunc;
   logic        q_eff;
   logic [15:0] fixed_len;
   logic [15:0] dec;
   logic        dec_zero;
   logic [15:0] rd_len;
   logic        len_zero;
   logic        len_ptr;
   logic [15:0] bl_step;
   logic [7:0]  lh_step;
   logic        iq_step;
   logic [15:0] dl_step;
   logic [7:0]  b;

   // handshake: take a byte whenever the result slot frees up this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;
   assign b            = req_if.data_byte;

   // shared decode of the current byte
   assign q_eff     = (phase_ff == PH_START) ? req_if.question_record : is_question_ff;
   assign fixed_len = q_eff ? Q_FIXED : RR_FIXED;
   assign dec       = bytes_left_ff - 16'd1;
   assign dec_zero  = (bytes_left_ff == 16'd1);
   assign rd_len    = {length_high_ff, b};
   assign len_zero  = (b == 8'd0);
   assign len_ptr   = ((b & PTR_MASK) != 8'd0);

   // record completion on this byte
   always_comb begin
      case (phase_ff)
         PH_FIXED: done = dec_zero && is_question_ff;
         PH_RDLO:  done = (rd_len == 16'd0);
         PH_RDATA: done = dec_zero;
         default:  done = 1'b0;
      endcase
   end

   assign trunc = req_if.last_byte && !done;

   // next phase
   always_comb begin
      case (phase_ff)
         PH_START, PH_LENGTH: begin
            if (len_zero) begin
               phase_in = PH_FIXED;
            end else if (len_ptr) begin
               phase_in = PH_PTR;
            end else begin
               phase_in = PH_LABEL;
            end
         end
         PH_LABEL: phase_in = dec_zero ? PH_LENGTH : PH_LABEL;
         PH_PTR:   phase_in = PH_FIXED;
         PH_FIXED: begin
            if (!dec_zero) begin
               phase_in = PH_FIXED;
            end else if (is_question_ff) begin
               phase_in = PH_START;
            end else begin
               phase_in = PH_RDHI;
            end
         end
         PH_RDHI:  phase_in = PH_RDLO;
         PH_RDLO:  phase_in = (rd_len == 16'd0) ? PH_START : PH_RDATA;
         PH_RDATA: phase_in = dec_zero ? PH_START : PH_RDATA;
         default:  phase_in = PH_START;
      endcase
      if (trunc) begin
         phase_in = PH_START;
      end
   end

   // counters, latched length and question flag
   always_comb begin
      bl_step = bytes_left_ff;
      lh_step = length_high_ff;
      iq_step = is_question_ff;
      dl_step = data_length_ff;
      case (phase_ff)
         PH_START, PH_LENGTH: begin
            if (phase_ff == PH_START) begin
               iq_step = req_if.question_record;
               dl_step = 16'd0;
            end
            if (len_zero) begin
               bl_step = fixed_len;
            end else if (!len_ptr) begin
               bl_step = {8'd0, b};
            end
         end
         PH_LABEL, PH_FIXED, PH_RDATA: bl_step = dec;
         PH_PTR:  bl_step = fixed_len;
         PH_RDHI: lh_step = b;
         PH_RDLO: begin
            dl_step = rd_len;
            if (rd_len != 16'd0) begin
               bl_step = rd_len;
            end
         end
         default: bl_step = bytes_left_ff;
      endcase
      // truncation drops the partial record
      bytes_left_in  = trunc ? 16'd0 : bl_step;
      length_high_in = trunc ? 8'd0  : lh_step;
      is_question_in = trunc ? 1'b0  : iq_step;
      data_length_in = trunc ? 16'd0 : dl_step;
   end

   // result register loads on accept, drains on the sink's ready
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      record_done_in  = record_done_ff;
      truncated_in    = truncated_ff;
      rdata_length_in = rdata_length_ff;
      if (req_accept) begin
         rsp_valid_in    = 1'b1;
         record_done_in  = done;
         truncated_in    = trunc;
         rdata_length_in = dl_step;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         bytes_left_ff  <= 16'd0;
         length_high_ff <= 8'd0;
         is_question_ff <= 1'b0;
         data_length_ff <= 16'd0;
      end else if (req_accept) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         length_high_ff <= length_high_in;
         is_question_ff <= is_question_in;
         data_length_ff <= data_length_in;
      end
   end

   // output slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      record_done_ff  <= record_done_in;
      truncated_ff    <= truncated_in;
      rdata_length_ff <= rdata_length_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.record_done  = record_done_ff;
   assign rsp_if.truncated    = truncated_ff;
   assign rsp_if.rdata_length = rdata_length_ff;

   // checks
   a_done_xor_trunc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(record_done_ff && truncated_ff))
      else $error("record_done and truncated both set");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_if.last_byte) |=> (phase_ff == PH_START))
      else $error("parser not at record start after last byte");

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && done) |=> (phase_ff == PH_START && record_done_ff))
      else $error("completed record did not restart parser");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LABEL || phase_ff == PH_FIXED || phase_ff == PH_RDATA)
         |-> (bytes_left_ff != 16'd0))
      else $error("skip counter empty in a counting phase");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule

// ----- bench/dns_record_skipper_top_test.sv -----
// self-checking testbench for the dns record skipper with per-byte result check
`timescale 1ns / 1ps

module dns_record_skipper_top_test
   import drs_pkg::*;
();

   // one packet byte with the question flag that rides along with it
   typedef struct {
      logic [7:0] data;
      logic       q;
   } wire_byte_type;

   // what the block reports for one byte
   typedef struct {
      logic        record_done;
      logic        truncated;
      logic [15:0] rdata_length;
   } byte_result_type;

   logic clock = 1'b0;
   logic reset;

   drs_req_if req_bus ();
   drs_rsp_if rsp_bus ();

   dns_record_skipper_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // record walker mirror
   phase_type    walk_phase;
   logic [15:0]  skip_left;
   logic [7:0]   len_high;
   logic         q_latched;
   logic [15:0]  rec_length;

   byte_result_type pending_results[$];
   wire_byte_type   packet_bytes[$];
   byte_result_type rsp_want;
   int           fail_count = 0;
   int           bytes_accepted = 0;
   int           stall_left = 0;
   bit           idling = 1'b1;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // record walker mirror
   // ---------------------------------------------------------------

   function automatic void clear_walk();
      walk_phase = PH_START;
      skip_left  = '0;
      len_high   = '0;
      q_latched  = 1'b0;
      rec_length = '0;
   endfunction

   // name is over: skip the fixed part of a question or a full record
   function automatic void finish_name();
      skip_left  = q_latched ? Q_FIXED : RR_FIXED;
      walk_phase = PH_FIXED;
   endfunction

   // zero ends the name, any top bit set is a pointer, else a plain label
   function automatic void take_label_length(logic [7:0] b);
      if (b == 8'd0) begin
         finish_name();
      end else if ((b & PTR_MASK) != 8'd0) begin
         walk_phase = PH_PTR;
      end else begin
         skip_left  = {8'd0, b};
         walk_phase = PH_LABEL;
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last, logic q);
      byte_result_type r;
      logic         done;
      done = 1'b0;
      case (walk_phase)
         PH_START: begin
            q_latched  = q;
            rec_length = '0;
            take_label_length(b);
         end
         PH_LENGTH: begin
            take_label_length(b);
         end
         PH_LABEL: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 16'd0) walk_phase = PH_LENGTH;
         end
         PH_PTR: begin
            finish_name();
         end
         PH_FIXED: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 16'd0) begin
               if (q_latched) begin
                  done       = 1'b1;
                  walk_phase = PH_START;
               end else begin
                  walk_phase = PH_RDHI;
               end
            end
         end
         PH_RDHI: begin
            len_high   = b;
            walk_phase = PH_RDLO;
         end
         PH_RDLO: begin
            rec_length = {len_high, b};
            if (rec_length == 16'd0) begin
               done       = 1'b1;
               walk_phase = PH_START;
            end else begin
               skip_left  = rec_length;
               walk_phase = PH_RDATA;
            end
         end
         default: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 16'd0) begin
               done       = 1'b1;
               walk_phase = PH_START;
            end
         end
      endcase
      r.record_done  = done;
      r.truncated    = last && !done;
      r.rdata_length = rec_length;
      pending_results.push_back(r);
      // buffer ran out mid-record: back to record start
      if (last && !done) clear_walk();
   endfunction

   // ---------------------------------------------------------------
   // packet building
   // ---------------------------------------------------------------

   function automatic void push_wire_byte(logic [7:0] d);
      wire_byte_type wb;
      wb.data = d;
      wb.q    = 1'($urandom_range(0, 1));
      packet_bytes.push_back(wb);
   endfunction

   // label_len 0 draws each label length from 1..6; ptr_type 0 ends the name with
   // a zero byte; rd_cap limits how many data bytes are actually appended
   function automatic void add_record(bit is_q, int labels, int label_len,
                                      logic [1:0] ptr_type, logic [15:0] rdlen,
                                      int rd_cap);
      int first;
      int len;
      first = packet_bytes.size();
      for (int i = 0; i < labels; i++) begin
         len = (label_len != 0) ? label_len : $urandom_range(1, 6);
         push_wire_byte(8'(len));
         repeat (len) push_wire_byte(8'($urandom_range(0, 255)));
      end
      if (ptr_type != 2'b00) begin
         push_wire_byte({ptr_type, 6'($urandom_range(0, 63))});
         push_wire_byte(8'($urandom_range(0, 255)));
      end else begin
         push_wire_byte(8'h00);
      end
      repeat (is_q ? Q_FIXED : RR_FIXED) push_wire_byte(8'($urandom_range(0, 255)));
      if (!is_q) begin
         push_wire_byte(rdlen[15:8]);
         push_wire_byte(rdlen[7:0]);
         for (int i = 0; i < rdlen && i < rd_cap; i++)
            push_wire_byte(8'($urandom_range(0, 255)));
      end
      packet_bytes[first].q = is_q;
   endfunction

   // ---------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------

   task automatic send_byte(logic [7:0] d, logic last, logic q);
      int gap;
      gap = idling ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.data_byte       <= d;
      req_bus.last_byte       <= last;
      req_bus.question_record <= q;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_accepted++;
      predict_byte(d, last, q);
   endtask

   // send the built packet; the byte at index cut carries last and ends the buffer
   task automatic send_packet(int cut);
      for (int i = 0; i < packet_bytes.size(); i++) begin
         send_byte(packet_bytes[i].data, i == cut, packet_bytes[i].q);
         if (i == cut) break;
      end
   endtask

   // ---------------------------------------------------------------
   // result check and receiver stalls
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result item with nothing predicted");
               fail_count++;
            end else begin
               rsp_want = pending_results.pop_front();
               if (rsp_bus.record_done !== rsp_want.record_done) begin
                  $error("record_done: expected %0d, got %0d",
                         rsp_want.record_done, rsp_bus.record_done);
                  fail_count++;
               end
               if (rsp_bus.truncated !== rsp_want.truncated) begin
                  $error("truncated: expected %0d, got %0d",
                         rsp_want.truncated, rsp_bus.truncated);
                  fail_count++;
               end
               if (rsp_bus.rdata_length !== rsp_want.rdata_length) begin
                  $error("rdata_length: expected %0d, got %0d",
                         rsp_want.rdata_length, rsp_bus.rdata_length);
                  fail_count++;
               end
            end
            stall_left = idling ? $urandom_range(0, 5) : 0;
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // root name, plain label and pointer names; last byte lands on a record end
   task automatic test_question_records();
      packet_bytes.delete();
      add_record(1'b1, 0, 0, 2'b00, 16'd0, 0);
      add_record(1'b1, 1, 0, 2'b11, 16'd0, 0);
      add_record(1'b1, 2, 0, 2'b00, 16'd0, 0);
      send_packet(packet_bytes.size() - 1);
   endtask

   // zero data length, longest label, reserved label types, short data
   task automatic test_answer_records();
      packet_bytes.delete();
      add_record(1'b0, 1, 63, 2'b01, 16'd0, 0);
      add_record(1'b0, 2, 0, 2'b10, 16'd3, 3);
      add_record(1'b0, 0, 0, 2'b00, 16'd1, 1);
      send_packet(packet_bytes.size() - 1);
   endtask

   // buffer ends in each phase of a record
   task automatic test_truncation();
      int cuts[6] = '{2, 4, 6, 13, 14, 16};
      // last byte on the very first byte of a record
      packet_bytes.delete();
      push_wire_byte(8'h00);
      send_packet(0);
      // label, name end, fixed part, length high, length low, data
      packet_bytes.delete();
      add_record(1'b0, 1, 3, 2'b00, 16'd5, 5);
      foreach (cuts[i]) send_packet(cuts[i]);
      // on the pointer byte and on the byte after it
      packet_bytes.delete();
      add_record(1'b1, 0, 0, 2'b11, 16'd0, 0);
      send_packet(0);
      send_packet(1);
      // largest data length, cut a few bytes into the data
      packet_bytes.delete();
      add_record(1'b0, 0, 0, 2'b00, 16'hffff, 3);
      send_packet(packet_bytes.size() - 1);
   endtask

   // well-formed packets with random content, plus stretches of noise
   task automatic test_random_packets(int target);
      int          start;
      int          nrec;
      int          cut;
      int          kind;
      int          noise_len;
      bit          is_q;
      bit          big;
      bit          open_rec;
      logic [1:0]  ptr_type;
      logic [15:0] rdlen;
      start = bytes_accepted;
      while (bytes_accepted - start < target) begin
         idling = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            // noise, closed by a last byte so the walk is back at record start
            noise_len = $urandom_range(1, 8);
            for (int i = 0; i <= noise_len; i++)
               send_byte(8'($urandom_range(0, 255)),
                         (i == noise_len) || ($urandom_range(0, 7) == 0),
                         1'($urandom_range(0, 1)));
         end else begin
            packet_bytes.delete();
            nrec     = $urandom_range(1, 4);
            open_rec = 1'b0;
            for (int r = 0; r < nrec && !open_rec; r++) begin
               is_q     = ($urandom_range(0, 2) == 0);
               big      = !is_q && ($urandom_range(0, 11) == 0);
               rdlen    = big ? 16'($urandom) : 16'($urandom_range(0, 12));
               ptr_type = $urandom_range(0, 1) ? 2'($urandom_range(1, 3)) : 2'b00;
               add_record(is_q, $urandom_range(0, 3),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : 0,
                          ptr_type, rdlen, big ? $urandom_range(0, 4) : int'(rdlen));
               // a long record is only partly sent, so the buffer must end in it
               open_rec = big;
            end
            kind = $urandom_range(0, 3);
            if (open_rec || kind == 1 || kind == 2) cut = packet_bytes.size() - 1;
            else if (kind == 0) cut = $urandom_range(0, packet_bytes.size() - 1);
            else cut = -1;
            send_packet(cut);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.data_byte       = 8'h00;
      req_bus.last_byte       = 1'b0;
      req_bus.question_record = 1'b0;
      rsp_bus.ready           = 1'b0;
      clear_walk();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_question_records();
      test_answer_records();
      test_truncation();
      test_random_packets(1750);

      // drain outstanding results
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
